/* src/bptc_pkg.sv */
`default_nettype none
package bptc_pkg;

    localparam int unsigned NUM_STAGES = 9;
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 64;

    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PRESS_A = 2'd1;
    localparam logic [1:0] REG_PRESS_B = 2'd2;
    localparam logic [1:0] REG_PRESS_C = 2'd3;

    localparam logic signed [63:0] FINE_MIN  = -64'sd8388608;
    localparam logic signed [63:0] FINE_MAX  = 64'sd8388607;
    localparam logic signed [63:0] TEMP_MIN  = -64'sd4000;
    localparam logic signed [63:0] TEMP_MAX  = 64'sd8500;
    localparam logic signed [63:0] PRESS_MIN = 64'sd3000000;
    localparam logic signed [63:0] PRESS_MAX = 64'sd12500000;
    localparam logic signed [63:0] COEF_BIAS = 64'sd16384;

    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } coeff_t;

    // Signed division by 2**sh that rounds toward zero.
    function automatic logic signed [63:0] tdiv_pow2(input logic signed [63:0] v,
                                                    input int unsigned sh);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
        return (v + bias) >>> sh;
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
        logic signed [63:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/bptc_datapath.sv */
`default_nettype none
module bptc_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [23:0]          raw_temperature,
    input  wire logic [23:0]          raw_pressure,
    input  wire bptc_pkg::coeff_t     coeff,
    output logic                      out_valid,
    output logic signed [23:0]        fine_temperature,
    output logic signed [14:0]        temperature_centideg,
    output logic [23:0]               pressure_centipascal
);
    import bptc_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;

    logic signed [24:0] at_reg, at_next;
    logic [23:0]        rp1_reg, rp2_reg, rp3_reg, rp4_reg, rp5_reg, rp6_reg;
    logic signed [41:0] bt_reg, bt_next;
    logic signed [49:0] ct_reg, ct_next;
    logic signed [27:0] lin3_reg, lin3_next, lin4_reg, lin5_reg, lin6_reg, lin7_reg, lin8_reg;
    logic signed [18:0] tc4_reg, tc4_next, tc5_reg, tc6_reg, tc7_reg, tc8_reg;
    logic signed [55:0] aa4_reg, aa4_next;
    logic signed [44:0] foff4_reg, foff4_next, foff5_reg;
    logic signed [45:0] esens4_reg, esens4_next, esens5_reg;
    logic signed [36:0] b104_reg, b104_next;
    logic signed [63:0] cw5_reg, cw5_next, eoff5_reg, eoff5_next, dsens5_reg, dsens5_next;
    logic signed [37:0] cpr5_reg, cpr5_next;
    logic [47:0]        f5_reg, f5_next;
    logic signed [63:0] offs6_reg, offs6_next, sens6_reg, sens6_next;
    logic signed [48:0] dpr6_reg, dpr6_next;
    logic signed [40:0] bq6_reg, bq6_next;
    logic signed [63:0] offs7_reg, offs7_next, apr7_reg, apr7_next;
    logic signed [63:0] epr7_reg, epr7_next, cpr7_reg, cpr7_next;
    logic signed [63:0] sum8_reg, sum8_next;
    logic signed [23:0] fine9_reg, fine9_next;
    logic signed [14:0] tc9_reg, tc9_next;
    logic [23:0]        pc9_reg, pc9_next;

    logic signed [63:0] e3, lin3_w, tc4_w, c6, d6, b6, dpr6_w, bq6_w;
    logic signed [63:0] s7, d7, q7, pm9, pc9_w, fine9_w, tc9_w, t6;

    always_comb begin
        valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};

        at_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.t1, 8'h00});

        bt_next = 42'($signed({1'b0, coeff.t2})) * 42'(at_reg);
        ct_next = 50'(at_reg) * 50'(at_reg);

        e3 = (64'(bt_reg) <<< 18) + 64'(ct_reg) * 64'(coeff.t3);
        lin3_w = tdiv_pow2(e3, 32);
        lin3_next = lin3_w[27:0];

        tc4_w = tdiv_pow2(64'(lin3_reg) * 64'sd25, 14);
        tc4_next = tc4_w[18:0];
        aa4_next = 56'(lin3_reg) * 56'(lin3_reg);
        foff4_next = 45'($signed({1'b0, coeff.p6})) * 45'(lin3_reg);
        esens4_next = (46'(coeff.p2) - 46'(COEF_BIAS)) * 46'(lin3_reg);
        b104_next = 37'(coeff.p10) * 37'(lin3_reg);

        cw5_next = (64'(aa4_reg) >>> 6) * 64'(lin4_reg);
        eoff5_next = (64'(coeff.p7) * 64'(aa4_reg)) <<< 4;
        dsens5_next = (64'(coeff.p3) * 64'(aa4_reg)) <<< 2;
        cpr5_next = 38'(b104_reg) + (38'(coeff.p9) <<< 16);
        f5_next = 48'(rp4_reg) * 48'(rp4_reg);

        c6 = tdiv_pow2(cw5_reg, 8);
        d6 = tdiv_pow2(64'(coeff.p8) * c6, 5);
        b6 = tdiv_pow2(64'(coeff.p4) * c6, 5);
        offs6_next = (64'(coeff.p5) <<< 47) + d6 + eoff5_reg + (64'(foff5_reg) <<< 22);
        t6 = 64'(coeff.p1) - COEF_BIAS;
        sens6_next = (t6 <<< 46) + b6 + dsens5_reg + (64'(esens5_reg) <<< 21);
        dpr6_w = tdiv_pow2(64'(cpr5_reg) * 64'(rp5_reg), 13);
        dpr6_next = dpr6_w[48:0];
        bq6_w = tdiv_pow2(64'(coeff.p11) * 64'(f5_reg), 16);
        bq6_next = bq6_w[40:0];

        s7 = tdiv_pow2(sens6_reg, 24);
        apr7_next = s7 * 64'(rp6_reg);
        d7 = 64'(dpr6_reg) * 64'(rp6_reg);
        epr7_next = tdiv_pow2(d7, 9);
        q7 = 64'(bq6_reg) * 64'(rp6_reg);
        cpr7_next = tdiv_pow2(q7, 7);
        offs7_next = tdiv_pow2(offs6_reg, 2);

        sum8_next = offs7_reg + apr7_reg + epr7_reg + cpr7_reg;

        pm9 = (sum8_reg <<< 4) + (sum8_reg <<< 3) + sum8_reg;
        pc9_w = clamp64(tdiv_pow2(pm9, 40), PRESS_MIN, PRESS_MAX);
        pc9_next = pc9_w[23:0];
        fine9_w = clamp64(64'(lin8_reg), FINE_MIN, FINE_MAX);
        fine9_next = fine9_w[23:0];
        tc9_w = clamp64(64'(tc8_reg), TEMP_MIN, TEMP_MAX);
        tc9_next = tc9_w[14:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            at_reg     <= at_next;
            rp1_reg    <= raw_pressure;
            bt_reg     <= bt_next;
            ct_reg     <= ct_next;
            rp2_reg    <= rp1_reg;
            lin3_reg   <= lin3_next;
            rp3_reg    <= rp2_reg;
            lin4_reg   <= lin3_reg;
            tc4_reg    <= tc4_next;
            aa4_reg    <= aa4_next;
            foff4_reg  <= foff4_next;
            esens4_reg <= esens4_next;
            b104_reg   <= b104_next;
            rp4_reg    <= rp3_reg;
            lin5_reg   <= lin4_reg;
            tc5_reg    <= tc4_reg;
            cw5_reg    <= cw5_next;
            eoff5_reg  <= eoff5_next;
            dsens5_reg <= dsens5_next;
            foff5_reg  <= foff4_reg;
            esens5_reg <= esens4_reg;
            cpr5_reg   <= cpr5_next;
            f5_reg     <= f5_next;
            rp5_reg    <= rp4_reg;
            lin6_reg   <= lin5_reg;
            tc6_reg    <= tc5_reg;
            offs6_reg  <= offs6_next;
            sens6_reg  <= sens6_next;
            dpr6_reg   <= dpr6_next;
            bq6_reg    <= bq6_next;
            rp6_reg    <= rp5_reg;
            lin7_reg   <= lin6_reg;
            tc7_reg    <= tc6_reg;
            offs7_reg  <= offs7_next;
            apr7_reg   <= apr7_next;
            epr7_reg   <= epr7_next;
            cpr7_reg   <= cpr7_next;
            lin8_reg   <= lin7_reg;
            tc8_reg    <= tc7_reg;
            sum8_reg   <= sum8_next;
            fine9_reg  <= fine9_next;
            tc9_reg    <= tc9_next;
            pc9_reg    <= pc9_next;
        end
    end

    assign out_valid            = valid_reg[NUM_STAGES-1];
    assign fine_temperature     = fine9_reg;
    assign temperature_centideg = tc9_reg;
    assign pressure_centipascal = pc9_reg;

endmodule
`default_nettype wire

/* src/barometer_temp_pressure_compensation_core.sv */
`default_nettype none
// Compensates one raw temperature and pressure sample pair per item and returns the fine
// temperature, the temperature in 0.01 degC and the pressure in 0.01 Pa, all saturated.
// The core accepts one item every clock cycle while the output is not stalled; the
// nine-stage multiply pipeline advances as a whole and holds while a result waits for
// m_tready. Calibration registers are written over the APB port at byte addresses 0, 8,
// 16 and 24 and must only change while idle.
module barometer_temp_pressure_compensation_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bptc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [bptc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [bptc_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // raw_temperature [23:0], raw_pressure [47:24]
    input  wire logic [47:0]                   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // fine_temperature [23:0], temperature_centideg [38:24],
    // pressure_centipascal [62:39], zero [63]
    output logic [63:0]                        m_tdata
);
    import bptc_pkg::*;

    logic [39:0] temp_coeffs_reg;
    logic [47:0] press_coeffs_a_reg;
    logic [47:0] press_coeffs_b_reg;
    logic [31:0] press_coeffs_c_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;
    logic        en;
    coeff_t      coeff;
    logic signed [23:0] fine_temperature;
    logic signed [14:0] temperature_centideg;
    logic [23:0]        pressure_centipascal;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg    <= '0;
            press_coeffs_a_reg <= '0;
            press_coeffs_b_reg <= '0;
            press_coeffs_c_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TEMP:    temp_coeffs_reg    <= pwdata[39:0];
                REG_PRESS_A: press_coeffs_a_reg <= pwdata[47:0];
                REG_PRESS_B: press_coeffs_b_reg <= pwdata[47:0];
                REG_PRESS_C: press_coeffs_c_reg <= pwdata[31:0];
                default:     temp_coeffs_reg    <= temp_coeffs_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TEMP:    prdata = 64'(temp_coeffs_reg);
            REG_PRESS_A: prdata = 64'(press_coeffs_a_reg);
            REG_PRESS_B: prdata = 64'(press_coeffs_b_reg);
            REG_PRESS_C: prdata = 64'(press_coeffs_c_reg);
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        coeff.t1  = temp_coeffs_reg[15:0];
        coeff.t2  = temp_coeffs_reg[31:16];
        coeff.t3  = temp_coeffs_reg[39:32];
        coeff.p1  = press_coeffs_a_reg[15:0];
        coeff.p2  = press_coeffs_a_reg[31:16];
        coeff.p3  = press_coeffs_a_reg[39:32];
        coeff.p4  = press_coeffs_a_reg[47:40];
        coeff.p5  = press_coeffs_b_reg[15:0];
        coeff.p6  = press_coeffs_b_reg[31:16];
        coeff.p7  = press_coeffs_b_reg[39:32];
        coeff.p8  = press_coeffs_b_reg[47:40];
        coeff.p9  = press_coeffs_c_reg[15:0];
        coeff.p10 = press_coeffs_c_reg[23:16];
        coeff.p11 = press_coeffs_c_reg[31:24];
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    bptc_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .en                   (en),
        .in_valid             (s_tvalid),
        .raw_temperature      (s_tdata[23:0]),
        .raw_pressure         (s_tdata[47:24]),
        .coeff                (coeff),
        .out_valid            (m_tvalid),
        .fine_temperature     (fine_temperature),
        .temperature_centideg (temperature_centideg),
        .pressure_centipascal (pressure_centipascal)
    );

    assign m_tdata = {1'b0, pressure_centipascal, temperature_centideg, fine_temperature};

    a_reset_idle: assert property (@(posedge aclk) $rose(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_press_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pressure_centipascal >= 24'd3000000 &&
                      pressure_centipascal <= 24'd12500000))
        else $error("pressure outside saturation range");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (temperature_centideg >= -15'sd4000 &&
                      temperature_centideg <= 15'sd8500))
        else $error("temperature outside saturation range");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline is stalled");

endmodule
`default_nettype wire

/* tb/tb_checker.sv */
`timescale 1ns / 1ps
module tb_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    output int               fail_count,
    output int               pending_count,
    output int               result_count
);
    import bptc_pkg::*;

    logic [39:0] temp_reg;
    logic [47:0] press_a_reg;
    logic [47:0] press_b_reg;
    logic [31:0] press_c_reg;
    logic [63:0] expected_results[$];

    function automatic logic signed [63:0] div_trunc(logic signed [63:0] v, int sh);
        logic signed [63:0] q;
        q = v >>> sh;
        if (v < 0 && (v & ((64'sd1 <<< sh) - 64'sd1)) != 0) q = q + 64'sd1;
        return q;
    endfunction

    function automatic logic signed [63:0] sat(logic signed [63:0] v,
                                               logic signed [63:0] lo,
                                               logic signed [63:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [63:0] compensate(logic [23:0] rt_in, logic [23:0] rp_in);
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        logic signed [63:0] rt, rp, a, b, c, d, e, f, lin, tc, offs, sens, sum, pc;
        logic signed [63:0] fine_s, temp_s, press_s;
        t1 = {48'd0, temp_reg[15:0]};
        t2 = {48'd0, temp_reg[31:16]};
        t3 = {{56{temp_reg[39]}}, temp_reg[39:32]};
        p1 = {{48{press_a_reg[15]}}, press_a_reg[15:0]};
        p2 = {{48{press_a_reg[31]}}, press_a_reg[31:16]};
        p3 = {{56{press_a_reg[39]}}, press_a_reg[39:32]};
        p4 = {{56{press_a_reg[47]}}, press_a_reg[47:40]};
        p5 = {48'd0, press_b_reg[15:0]};
        p6 = {48'd0, press_b_reg[31:16]};
        p7 = {{56{press_b_reg[39]}}, press_b_reg[39:32]};
        p8 = {{56{press_b_reg[47]}}, press_b_reg[47:40]};
        p9 = {{48{press_c_reg[15]}}, press_c_reg[15:0]};
        p10 = {{56{press_c_reg[23]}}, press_c_reg[23:16]};
        p11 = {{56{press_c_reg[31]}}, press_c_reg[31:24]};
        rt = {40'd0, rt_in};
        rp = {40'd0, rp_in};
        a = rt - 64'sd256 * t1;
        b = t2 * a;
        c = a * a;
        d = c * t3;
        e = b * 64'sd262144 + d;
        lin = div_trunc(e, 32);
        tc = div_trunc(lin * 64'sd25, 14);
        a = lin * lin;
        b = div_trunc(a, 6);
        c = div_trunc(b * lin, 8);
        d = div_trunc(p8 * c, 5);
        e = p7 * a * 64'sd16;
        f = p6 * lin * 64'sd4194304;
        offs = p5 * 64'sd140737488355328 + d + e + f;
        b = div_trunc(p4 * c, 5);
        d = p3 * a * 64'sd4;
        e = (p2 - 64'sd16384) * lin * 64'sd2097152;
        sens = (p1 - 64'sd16384) * 64'sd70368744177664 + b + d + e;
        a = div_trunc(sens, 24) * rp;
        b = p10 * lin;
        c = b + 64'sd65536 * p9;
        d = div_trunc(c * rp, 13);
        e = div_trunc(d * rp, 9);
        f = rp * rp;
        b = div_trunc(p11 * f, 16);
        c = div_trunc(b * rp, 7);
        sum = div_trunc(offs, 2) + a + e + c;
        pc = div_trunc(sum * 64'sd25, 40);
        fine_s = sat(lin, -64'sd8388608, 64'sd8388607);
        temp_s = sat(tc, -64'sd4000, 64'sd8500);
        press_s = sat(pc, 64'sd3000000, 64'sd12500000);
        return {1'b0, press_s[23:0], temp_s[14:0], fine_s[23:0]};
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        logic [63:0] want;
        if (!aresetn) begin
            temp_reg <= '0;
            press_a_reg <= '0;
            press_b_reg <= '0;
            press_c_reg <= '0;
            fail_count <= 0;
            result_count <= 0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    REG_TEMP:    temp_reg <= pwdata[39:0];
                    REG_PRESS_A: press_a_reg <= pwdata[47:0];
                    REG_PRESS_B: press_b_reg <= pwdata[47:0];
                    REG_PRESS_C: press_c_reg <= pwdata[31:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(compensate(s_tdata[23:0], s_tdata[47:24]));
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("Unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== m_tdata) begin
                        if (fail_count < 10)
                            $display("Result %0d: fine exp %h got %h, temp exp %h got %h, press exp %h got %h",
                                     result_count, want[23:0], m_tdata[23:0], want[38:24],
                                     m_tdata[38:24], want[62:39], m_tdata[62:39]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import bptc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    int          sent_items = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    barometer_temp_pressure_compensation_core u_dut (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    tb_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
    );

    // The result side stalls in random bursts until the calm part of the run.
    always @(posedge aclk) begin
        int burst;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (m_tready) begin
            if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (burst) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_count != 0) @(posedge aclk);
        repeat (NUM_STAGES + 4) @(posedge aclk);
    endtask

    task automatic send_sample(logic [23:0] rt, logic [23:0] rp);
        s_tvalid <= 1'b1;
        s_tdata <= {rp, rt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic finish_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Typical calibration close to a real part, with a little random spread.
    task automatic load_typical();
        write_reg(REG_TEMP, {8'hF9, 16'd27000 + 16'($urandom_range(0, 2000)),
                             16'd27500 + 16'($urandom_range(0, 500))});
        write_reg(REG_PRESS_A, {8'h00, 8'($urandom_range(0, 3)), 16'hFFF0
                                + 16'($urandom_range(0, 31)), 16'h0100
                                + 16'($urandom_range(0, 255))});
        write_reg(REG_PRESS_B, {8'hFC, 8'h04, 16'd32000 + 16'($urandom_range(0, 2000)),
                                16'd25000 + 16'($urandom_range(0, 2000))});
        write_reg(REG_PRESS_C, {8'hFE, 8'h00, 16'h0010 + 16'($urandom_range(0, 31))});
    endtask

    initial begin
        logic [23:0] edge_vals[4];
        int phase;
        edge_vals = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // All coefficients at reset value zero first.
        for (int i = 0; i < 4; i++) send_sample(edge_vals[i], edge_vals[3 - i]);
        finish_burst();
        wait_drained();

        load_typical();
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) send_sample(edge_vals[i], edge_vals[j]);
        send_sample(24'd6950000, 24'd6500000);
        send_sample(24'd8400000, 24'd7000000);
        finish_burst();
        wait_drained();

        // Extreme coefficients drive wrapping intermediates and saturation.
        write_reg(REG_TEMP, 64'hFF_FFFF_FFFF);
        write_reg(REG_PRESS_A, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_PRESS_B, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_PRESS_C, 64'hFFFF_FFFF);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'h000000, 24'h000000);
        send_sample(24'h123456, 24'hABCDEF);
        finish_burst();
        wait_drained();

        for (phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                calm = 1'b1;
                load_typical();
            end else if (phase % 2 == 0) begin
                load_typical();
            end else begin
                write_reg(REG_TEMP, rand64());
                write_reg(REG_PRESS_A, rand64());
                write_reg(REG_PRESS_B, rand64());
                write_reg(REG_PRESS_C, rand64());
            end
            repeat (100) begin
                if ($urandom_range(0, 3) != 0)
                    send_sample(24'($urandom_range(6000000, 9000000)),
                                24'($urandom_range(5000000, 8000000)));
                else
                    send_sample(24'($urandom()), 24'($urandom()));
            end
            finish_burst();
            wait_drained();
        end

        $display("Sent %0d items over nine calibration settings, %0d results checked.",
                 sent_items, result_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
